[sv/hmcn_pkg.sv]
// ----------------------------------------------------------------------------
// hmcn_pkg
// Shared constants for the heightmap corner height and normal block.
// ----------------------------------------------------------------------------
package hmcn_pkg;

	// default store size
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	// coordinate width, enough for the largest store plus a wrap for -1
	localparam int CRD_W = 13;

	// register reset values
	localparam logic [8:0] GRID_RST = 9'd256;

	// normal arithmetic
	localparam logic [20:0] SLOPE_SQ = 21'd2601;   // 51*51
	localparam logic [9:0]  SLOPE_DEN = 10'd51;
	localparam logic [15:0] ONE_Q14  = 16'd16384;
	localparam logic [14:0] RECIP3   = 15'd21846;  // ceil(2^16/3)
	localparam int DIV_STEPS  = 30;
	localparam int SQRT_STEPS = 15;

	// register indexes
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	// commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

endpackage

[sv/heightmap_corner_height_and_normal.sv]
// ----------------------------------------------------------------------------
// heightmap_corner_height_and_normal
// Height image store with corner height averaging and unit normal output.
// ----------------------------------------------------------------------------
// A write transfer leaves the block idle, so it stays ready for the next transfer.
// A query runs from acceptance to a valid result: nine reads of the store,
// four corner averages, then three components of one shared subtractor
// (30 divide steps and 15 square root steps each).
// The block takes no new query until the last result is built; a result held
// by m_tready stalls the next query in its final state.
// Reset clears control and the grid registers; the store is not cleared.
module heightmap_corner_height_and_normal #(
	parameter int MAX_WIDTH  = hmcn_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = hmcn_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // col[7:0], row[15:8], pixel[23:16]
	input  logic        s_tuser,   // cmd
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// height_tl[9:0], height_tr[19:10], height_bl[29:20], height_br[39:30],
	// normal_x[55:40], normal_y[71:56], normal_z[87:72]
	output logic [87:0] m_tdata
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 2 ** AW;
	localparam int CW    = hmcn_pkg::CRD_W;
	localparam logic [CW-1:0] MAXW_C = CW'(MAX_WIDTH);
	localparam logic [CW-1:0] MAXH_C = CW'(MAX_HEIGHT);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_FETCH = 4'd1;
	localparam logic [3:0] ST_HGT   = 4'd2;
	localparam logic [3:0] ST_LEN   = 4'd3;
	localparam logic [3:0] ST_MAG   = 4'd4;
	localparam logic [3:0] ST_DIV   = 4'd5;
	localparam logic [3:0] ST_SQRT  = 4'd6;
	localparam logic [3:0] ST_COMP  = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [3:0]  state_q;
	logic [4:0]  cnt_q;
	logic [1:0]  fx_q, fy_q;
	logic [1:0]  comp_q;
	logic [8:0]  gw_q, gh_q;
	logic [7:0]  qcol_q, qrow_q;
	logic [7:0]  pix_q [9];
	logic [8:0]  pv_q;
	logic [9:0]  h_q [4];
	logic [21:0] sq_q;
	logic [20:0] len2_q;
	logic [20:0] rem_q;
	logic [29:0] quot_q;
	logic [14:0] root_q;
	logic        eq_q;
	logic [15:0] n_q [3];
	logic [7:0]  rd_q;
	logic [7:0]  mem [DEPTH];

	// ---------------- configuration port ----------------
	logic cfg_we;
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == hmcn_pkg::REG_GRID_HEIGHT) ? {23'd0, gh_q} : {23'd0, gw_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= hmcn_pkg::GRID_RST;
			gh_q <= hmcn_pkg::GRID_RST;
		end else if (cfg_we) begin
			if (paddr[2] == hmcn_pkg::REG_GRID_WIDTH) gw_q <= pwdata[8:0];
			else gh_q <= pwdata[8:0];
		end
	end

	// effective grid size, clamped to [1, max]
	logic [CW-1:0] w_eff, h_eff;
	always_comb begin
		if (gw_q == 9'd0) w_eff = CW'(1);
		else if (CW'(gw_q) > MAXW_C) w_eff = MAXW_C;
		else w_eff = CW'(gw_q);
		if (gh_q == 9'd0) h_eff = CW'(1);
		else if (CW'(gh_q) > MAXH_C) h_eff = MAXH_C;
		else h_eff = CW'(gh_q);
	end

	// ---------------- height store ----------------
	logic          s_acc;
	logic          mem_we;
	logic [CW-1:0] wx, wy, fx, fy;
	logic [AW-1:0] waddr, raddr;
	logic          f_valid;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign wx       = CW'(s_tdata[7:0]);
	assign wy       = CW'(s_tdata[15:8]);
	assign mem_we   = s_acc && (s_tuser == hmcn_pkg::CMD_WRITE) && (wx < MAXW_C) && (wy < MAXH_C);
	assign waddr    = {wy[YW-1:0], wx[XW-1:0]};

	// fetch position: (col-1+fx, row-1+fy), -1 wraps far out of range
	assign fx      = CW'(qcol_q) + CW'(fx_q) - CW'(1);
	assign fy      = CW'(qrow_q) + CW'(fy_q) - CW'(1);
	assign raddr   = {fy[YW-1:0], fx[XW-1:0]};
	assign f_valid = (fx < w_eff) && (fy < h_eff);

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= s_tdata[23:16];
		rd_q <= mem[raddr];
	end

	// ---------------- corner average ----------------
	logic [7:0]  cp [4];
	logic [3:0]  cv;
	logic [9:0]  csum;
	logic [2:0]  cn;
	logic [11:0] c4s1;
	logic [26:0] c3prod;
	logic [9:0]  chgt;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: begin
				cp[0] = pix_q[0]; cp[1] = pix_q[1]; cp[2] = pix_q[3]; cp[3] = pix_q[4];
				cv = {pv_q[4], pv_q[3], pv_q[1], pv_q[0]};
			end
			2'd1: begin
				cp[0] = pix_q[1]; cp[1] = pix_q[2]; cp[2] = pix_q[4]; cp[3] = pix_q[5];
				cv = {pv_q[5], pv_q[4], pv_q[2], pv_q[1]};
			end
			2'd2: begin
				cp[0] = pix_q[3]; cp[1] = pix_q[4]; cp[2] = pix_q[6]; cp[3] = pix_q[7];
				cv = {pv_q[7], pv_q[6], pv_q[4], pv_q[3]};
			end
			default: begin
				cp[0] = pix_q[4]; cp[1] = pix_q[5]; cp[2] = pix_q[7]; cp[3] = pix_q[8];
				cv = {pv_q[8], pv_q[7], pv_q[5], pv_q[4]};
			end
		endcase
		csum = 10'd0;
		for (int i = 0; i < 4; i++) begin
			if (cv[i]) csum = csum + 10'(cp[i]);
		end
		cn     = 3'($countones(cv));
		c4s1   = {csum, 2'b01};
		c3prod = 27'(c4s1) * 27'(hmcn_pkg::RECIP3);
		unique case (cn)
			3'd1:    chgt = {csum[7:0], 2'b00};
			3'd2:    chgt = {csum[8:0], 1'b0};
			3'd3:    chgt = c3prod[25:16];
			3'd4:    chgt = csum;
			default: chgt = 10'd0;
		endcase
	end

	// ---------------- slopes and shared units ----------------
	logic signed [10:0] dx, dz;
	logic [9:0]  adx, adz, mag;
	logic        neg;
	logic [9:0]  mul_a;
	logic [21:0] mul_p;
	logic [21:0] sub_a, sub_b;
	logic [22:0] sub_r;
	logic        sub_ge;
	logic [15:0] qv;

	assign dx  = 11'(h_q[1]) - 11'(h_q[0]);
	assign dz  = 11'(h_q[2]) - 11'(h_q[0]);
	assign adx = dx[10] ? 10'(-dx) : dx[9:0];
	assign adz = dz[10] ? 10'(-dz) : dz[9:0];

	always_comb begin
		unique case (comp_q)
			2'd0:    begin mag = adx; neg = dx[10]; end
			2'd1:    begin mag = hmcn_pkg::SLOPE_DEN; neg = 1'b1; end
			default: begin mag = adz; neg = dz[10]; end
		endcase
	end

	// one squarer for len2 and magnitudes
	always_comb begin
		if (state_q == ST_LEN && cnt_q[0] == 1'b0) mul_a = adx;
		else if (state_q == ST_LEN) mul_a = adz;
		else mul_a = mag;
		mul_p = 22'(mul_a) * 22'(mul_a);
	end

	// one subtractor for compare, divide and square root steps
	always_comb begin
		unique case (state_q)
			ST_DIV: begin
				sub_a = {rem_q, 1'b0};
				sub_b = {1'b0, len2_q};
			end
			ST_SQRT: begin
				sub_a = {rem_q[19:0], quot_q[29:28]};
				sub_b = {5'd0, root_q, 2'b01};
			end
			default: begin
				sub_a = mul_p;
				sub_b = {1'b0, len2_q};
			end
		endcase
		sub_r  = {1'b0, sub_a} - {1'b0, sub_b};
		sub_ge = !sub_r[22];
	end

	// largest q with 2q-1 <= root
	assign qv = eq_q ? hmcn_pkg::ONE_Q14 : 16'((17'(root_q) + 17'd1) >> 1);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= 5'd0;
			fx_q     <= 2'd0;
			fy_q     <= 2'd0;
			comp_q   <= 2'd0;
			m_tvalid <= 1'b0;
		end else begin
			// result register: load from the final state, clear on transfer
			if (state_q == ST_FIN && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc && s_tuser == hmcn_pkg::CMD_QUERY) begin
						state_q <= ST_FETCH;
						cnt_q   <= 5'd0;
						fx_q    <= 2'd0;
						fy_q    <= 2'd0;
					end
				end
				ST_FETCH: begin
					if (fx_q == 2'd2) begin
						fx_q <= 2'd0;
						fy_q <= fy_q + 2'd1;
					end else begin
						fx_q <= fx_q + 2'd1;
					end
					if (cnt_q == 5'd9) begin
						state_q <= ST_HGT;
						cnt_q   <= 5'd0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_HGT: begin
					if (cnt_q == 5'd3) begin
						state_q <= ST_LEN;
						cnt_q   <= 5'd0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_LEN: begin
					if (cnt_q == 5'd1) begin
						state_q <= ST_MAG;
						comp_q  <= 2'd0;
						cnt_q   <= 5'd0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_MAG: begin
					state_q <= ST_DIV;
					cnt_q   <= 5'd0;
				end
				ST_DIV: begin
					if (cnt_q == 5'(hmcn_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_SQRT;
						cnt_q   <= 5'd0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == 5'(hmcn_pkg::SQRT_STEPS - 1)) begin
						state_q <= ST_COMP;
						cnt_q   <= 5'd0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_COMP: begin
					if (comp_q == 2'd2) begin
						state_q <= ST_FIN;
					end else begin
						comp_q  <= comp_q + 2'd1;
						state_q <= ST_MAG;
					end
				end
				ST_FIN: begin
					if (!m_tvalid || m_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (s_acc && s_tuser == hmcn_pkg::CMD_QUERY) begin
			qcol_q <= s_tdata[7:0];
			qrow_q <= s_tdata[15:8];
		end
		if (state_q == ST_FETCH) begin
			if (cnt_q != 5'd9) pv_q[cnt_q[3:0]] <= f_valid;
			if (cnt_q != 5'd0) pix_q[cnt_q[3:0] - 4'd1] <= rd_q;
		end
		if (state_q == ST_HGT) h_q[cnt_q[1:0]] <= chgt;
		if (state_q == ST_LEN) begin
			if (cnt_q[0] == 1'b0) sq_q <= mul_p;
			else len2_q <= 21'(sq_q + mul_p + 22'(hmcn_pkg::SLOPE_SQ));
		end
		if (state_q == ST_MAG) begin
			rem_q <= mul_p[20:0];
			eq_q  <= sub_ge;
		end
		if (state_q == ST_DIV) begin
			quot_q <= {quot_q[28:0], sub_ge};
			// last step clears remainder and root for the square root
			if (cnt_q == 5'(hmcn_pkg::DIV_STEPS - 1)) begin
				rem_q  <= 21'd0;
				root_q <= 15'd0;
			end else begin
				rem_q <= sub_ge ? sub_r[20:0] : sub_a[20:0];
			end
		end
		if (state_q == ST_SQRT) begin
			rem_q  <= sub_ge ? sub_r[20:0] : sub_a[20:0];
			root_q <= {root_q[13:0], sub_ge};
			quot_q <= {quot_q[27:0], 2'b00};
		end
		if (state_q == ST_COMP) n_q[comp_q] <= neg ? 16'(-qv) : qv;
		if (state_q == ST_FIN && (!m_tvalid || m_tready)) begin
			m_tdata <= {n_q[2], n_q[1], n_q[0], h_q[3], h_q[2], h_q[1], h_q[0]};
		end
	end

`ifndef SYNTHESIS
	// a query holds off further input until its result is built
	ast_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == hmcn_pkg::CMD_QUERY) |=> !s_tready)
		else $error("input accepted while query in progress");

	// results appear only out of the final state
	ast_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_FIN)
		else $error("result valid without finished query");

	// normal_y is strictly negative
	ast_ny_neg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[71] == 1'b1))
		else $error("normal_y not negative");

	// top-left and bottom-right corner heights stay in range
	ast_h_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:0] <= 10'd1020 && m_tdata[39:30] <= 10'd1020))
		else $error("corner height out of range");
`endif

endmodule
